FILE: sv/hbb_pkg.sv
// Shared types, codes and widths for the host byte bridge FIFOs.
// Used by the front end, the back end and the top level; depends on nothing.
package hbb_pkg;

   localparam int DEPTH_LOG2_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int ACTION_W = 3;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;
   localparam int STATUS_W = 2;
   localparam int NEED_W = 3;
   localparam int KIND_W = 3;

   localparam logic [ACTION_W-1:0] ACT_HOST_WRITE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_HOST_READ = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_QUEUE_SEND = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BYTE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_POP_WORD = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_POP_DWORD = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 3'd6;

   localparam logic [KIND_W-1:0] KIND_NOP = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HREAD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SEND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POP = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PEEK = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NEED_W-1:0] need;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [2:0] pad;
      logic [STATUS_W-1:0] status;
      logic rx_empty;
      logic [BYTE_W-1:0] rx_count;
      logic [WORD_W-1:0] pop_data;
      logic ready_res;
      logic host_load;
      logic [BYTE_W-1:0] host_byte;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

FILE: sv/host_byte_bridge_fifos.sv
// Byte mailbox between a host bus and local firmware, with receive and
// transmit rings of 2**DEPTH_LOG2 bytes each.
// The req channel carries one command word: req_tuser holds the action
// (host write, host read, queue send, pop byte, pop word, pop dword, peek)
// and req_tdata the byte written or queued. The rsp channel returns exactly
// one response word per command, in order, with the loaded host byte, the
// ready line, the popped value, the receive fill and the status.
// A command is accepted from a two-entry queue, so the requester can run
// ahead of the execution unit, which executes one command at a time.
// Writes, sends, refused pops and host reads of an empty transmit ring go
// straight to the response state; a host read of a waiting byte first
// reads the transmit ring, and a pop or peek reads its bytes one at a time
// through the single read port of the receive ring memory.
// Reset empties both rings, drops the ready line and clears the queue; ring
// contents are not cleared and no clearing pass is needed. When the receiver
// stalls rsp, one finished response waits in the output register while the
// next command is executed, and the queue then fills and deasserts req_tready.
module host_byte_bridge_fifos #(
   parameter int DEPTH_LOG2 = hbb_pkg::DEPTH_LOG2_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [hbb_pkg::BYTE_W-1:0] req_tdata,     // data_in
   input  logic [hbb_pkg::ACTION_W-1:0] req_tuser,   // action
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // host_byte, host_load, ready_res, pop_data, rx_count, rx_empty, status, zero pad
   output logic [hbb_pkg::RSP_W-1:0] rsp_tdata
);
   import hbb_pkg::*;

   logic cmd_valid;
   logic cmd_pop;
   cmd_type cmd;

   hbb_front u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .cmd_valid(cmd_valid),
      .cmd_pop(cmd_pop),
      .cmd(cmd)
   );

   hbb_back #(
      .DEPTH_LOG2(DEPTH_LOG2)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd_pop(cmd_pop),
      .cmd(cmd),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

`ifndef ASSERT_OFF
   rsp_type rsp_view;
   assign rsp_view = rsp_tdata;

   a_full_queue_has_cmd: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> cmd_valid)
      else $error("command queue full but reports no command");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.rx_empty |-> rsp_view.rx_count == '0)
      else $error("receive ring empty with nonzero count");

   a_no_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_view.host_load |-> rsp_view.host_byte == '0)
      else $error("host byte nonzero without a load");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.status == STAT_SHORT |-> rsp_view.pop_data == '0)
      else $error("refused pop returned data");
`endif

endmodule

FILE: sv/hbb_front.sv
// Front end: accepts request words, decodes the action into a command and
// holds commands in a short queue for the back end. Depends on hbb_pkg.
module hbb_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [hbb_pkg::BYTE_W-1:0] req_tdata,     // data_in
   input  logic [hbb_pkg::ACTION_W-1:0] req_tuser,   // action
   output logic cmd_valid,
   input  logic cmd_pop,
   output hbb_pkg::cmd_type cmd
);
   import hbb_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type q_ff [QUEUE_DEPTH];
   cmd_type decoded;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   always_comb begin
      decoded.data = req_tdata;
      case (req_tuser)
         ACT_HOST_WRITE: begin
            decoded.kind = KIND_PUSH;
            decoded.need = 3'd0;
         end
         ACT_HOST_READ: begin
            decoded.kind = KIND_HREAD;
            decoded.need = 3'd0;
         end
         ACT_QUEUE_SEND: begin
            decoded.kind = KIND_SEND;
            decoded.need = 3'd0;
         end
         ACT_POP_BYTE: begin
            decoded.kind = KIND_POP;
            decoded.need = 3'd1;
         end
         ACT_POP_WORD: begin
            decoded.kind = KIND_POP;
            decoded.need = 3'd2;
         end
         ACT_POP_DWORD: begin
            decoded.kind = KIND_POP;
            decoded.need = 3'd4;
         end
         ACT_PEEK: begin
            decoded.kind = KIND_PEEK;
            decoded.need = 3'd1;
         end
         default: begin
            decoded.kind = KIND_NOP;
            decoded.need = 3'd0;
         end
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd = q_ff[rd_ptr_ff];
   assign push = req_tvalid && req_tready;
   assign pop = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: sv/hbb_back.sv
// Back end: executes queued commands against the receive and transmit rings
// and registers one response word per command. Depends on hbb_pkg.
module hbb_back #(
   parameter int DEPTH_LOG2 = hbb_pkg::DEPTH_LOG2_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_pop,
   input  hbb_pkg::cmd_type cmd,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [hbb_pkg::RSP_W-1:0] rsp_tdata
);
   import hbb_pkg::*;

   localparam int DEPTH = 1 << DEPTH_LOG2;
   localparam int CMP_W = DEPTH_LOG2 + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP = 2'd1;
   localparam logic [1:0] S_TXGET = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [BYTE_W-1:0] rx_mem [DEPTH];
   logic [BYTE_W-1:0] tx_mem [DEPTH];
   logic [BYTE_W-1:0] rx_rdata_ff, tx_rdata_ff;
   logic rx_we, rx_re, tx_we, tx_re;
   logic [BYTE_W-1:0] wr_byte;

   logic [1:0] state_ff, state_in;
   logic [DEPTH_LOG2-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [DEPTH_LOG2-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic pending_ff, pending_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rd_pend_ff, rd_pend_in;
   logic peek_ff, peek_in;
   logic [NEED_W-1:0] need_ff, need_in, issued_ff, issued_in;
   logic [1:0] got_ff, got_in;

   logic [BYTE_W-1:0] host_byte_ff, host_byte_in;
   logic host_load_ff, host_load_in;
   logic [WORD_W-1:0] pop_data_ff, pop_data_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   rsp_type rsp_ff, rsp_in;

   logic [DEPTH_LOG2-1:0] rx_fill, tx_fill;

   assign rx_fill = rx_head_ff - rx_tail_ff;
   assign tx_fill = tx_head_ff - tx_tail_ff;
   assign wr_byte = cmd.data;

   always_comb begin
      state_in = state_ff;
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      pending_in = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_pend_in = 1'b0;
      peek_in = peek_ff;
      need_in = need_ff;
      issued_in = issued_ff;
      got_in = got_ff;
      host_byte_in = host_byte_ff;
      host_load_in = host_load_ff;
      pop_data_in = pop_data_ff;
      status_in = status_ff;
      rsp_in = rsp_ff;
      rx_we = 1'b0;
      rx_re = 1'b0;
      tx_we = 1'b0;
      tx_re = 1'b0;
      cmd_pop = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               host_byte_in = '0;
               host_load_in = 1'b0;
               pop_data_in = '0;
               status_in = STAT_OK;
               need_in = cmd.need;
               peek_in = (cmd.kind == KIND_PEEK);
               issued_in = '0;
               got_in = '0;
               state_in = S_DONE;
               case (cmd.kind)
                  KIND_PUSH: begin
                     if (rx_fill == '1) begin
                        status_in = STAT_FULL;
                     end else begin
                        rx_we = 1'b1;
                        rx_head_in = rx_head_ff + 1'b1;
                     end
                  end
                  KIND_HREAD: begin
                     host_load_in = 1'b1;
                     if (tx_fill != '0) begin
                        tx_re = 1'b1;
                        tx_tail_in = tx_tail_ff + 1'b1;
                        state_in = S_TXGET;
                     end else begin
                        pending_in = 1'b0;
                     end
                  end
                  KIND_SEND: begin
                     if (!pending_ff) begin
                        host_byte_in = cmd.data;
                        host_load_in = 1'b1;
                        pending_in = 1'b1;
                     end else if (tx_fill == '1) begin
                        status_in = STAT_FULL;
                     end else begin
                        tx_we = 1'b1;
                        tx_head_in = tx_head_ff + 1'b1;
                     end
                  end
                  KIND_POP, KIND_PEEK: begin
                     if (CMP_W'(rx_fill) < CMP_W'(cmd.need)) begin
                        status_in = STAT_SHORT;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            if (issued_ff != need_ff) begin
               rx_re = 1'b1;
               rd_pend_in = 1'b1;
               issued_in = issued_ff + 1'b1;
               if (!peek_ff) begin
                  rx_tail_in = rx_tail_ff + 1'b1;
               end
            end
            if (rd_pend_ff) begin
               pop_data_in[{got_ff, 3'b000} +: BYTE_W] = rx_rdata_ff;
               got_in = got_ff + 1'b1;
               if ({1'b0, got_ff} + 3'd1 == need_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_TXGET: begin
            host_byte_in = tx_rdata_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_in.pad = '0;
               rsp_in.status = status_ff;
               rsp_in.rx_empty = (rx_fill == '0);
               rsp_in.rx_count = BYTE_W'(rx_fill);
               rsp_in.pop_data = pop_data_ff;
               rsp_in.ready_res = pending_ff;
               rsp_in.host_load = host_load_ff;
               rsp_in.host_byte = host_byte_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         peek_ff <= 1'b0;
         need_ff <= '0;
         issued_ff <= '0;
         got_ff <= '0;
      end else begin
         state_ff <= state_in;
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         peek_ff <= peek_in;
         need_ff <= need_in;
         issued_ff <= issued_in;
         got_ff <= got_in;
      end
   end

   always_ff @(posedge clock) begin
      host_byte_ff <= host_byte_in;
      host_load_ff <= host_load_in;
      pop_data_ff <= pop_data_in;
      status_ff <= status_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_head_ff] <= wr_byte;
      end
      if (rx_re) begin
         rx_rdata_ff <= rx_mem[rx_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_head_ff] <= wr_byte;
      end
      if (tx_re) begin
         tx_rdata_ff <= tx_mem[tx_tail_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

endmodule
